// ===== design/quaternion_to_euler_angles_macros.svh =====
// Assertion macros used by the checker file.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define Q2E_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/q2e_pkg.sv =====
package q2e_pkg;

    localparam int IN_W    = 32;
    localparam int PROD_W  = 34;
    localparam int OPW     = 36;
    localparam int NW      = 32;
    localparam int ZW      = 28;
    localparam int SHW     = $clog2(OPW);
    localparam int Q_BITS  = 30;
    localparam int Q_ONE   = 1 << Q_BITS;

    localparam int PITCH_W   = 15;
    localparam int ANG_W     = 16;
    localparam int PITCH_LIM = 11521;
    localparam int ANG_LIM   = 23041;

    localparam int ITERS      = 20;
    localparam int NORM_MSB   = 28;
    localparam int PI_Q24     = 52707179;
    localparam int SQ_W       = 61;
    localparam int SQRT_ITERS = 31;

    // Degree scaling: round(|z| * 36672 / (5 * 2^24)).
    localparam int DEG_MUL     = 36672;
    localparam int DEG_RND     = 41943040;
    localparam int DEG_SHIFT   = 24;
    localparam int DEG_DIV     = 5;
    localparam int RECIP       = 209715;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 18;
    localparam int PW          = ZW + 17;

    localparam int PRE_LAT    = 3;
    localparam int CORDIC_LAT = 4 + ITERS + 3;
    localparam int TOTAL_LAT  = PRE_LAT + 1 + SQRT_ITERS + CORDIC_LAT;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [OPW-1:0]    opnd_t;

    function automatic prod_t mulq(input logic signed [IN_W-1:0] a,
                                   input logic signed [IN_W-1:0] b);
        logic signed [2*IN_W-1:0] p;
        begin
            p = a * b;
            return p[2*IN_W-1:Q_BITS];
        end
    endfunction

    function automatic logic signed [ZW-1:0] atan_q24(input int idx);
        case (idx)
            0:       return ZW'(13176795);
            1:       return ZW'(7778716);
            2:       return ZW'(4110060);
            3:       return ZW'(2086331);
            4:       return ZW'(1047214);
            5:       return ZW'(524117);
            6:       return ZW'(262123);
            7:       return ZW'(131069);
            8:       return ZW'(65536);
            9:       return ZW'(32768);
            10:      return ZW'(16384);
            11:      return ZW'(8192);
            12:      return ZW'(4096);
            13:      return ZW'(2048);
            14:      return ZW'(1024);
            15:      return ZW'(512);
            16:      return ZW'(256);
            17:      return ZW'(128);
            18:      return ZW'(64);
            19:      return ZW'(32);
            default: return '0;
        endcase
    endfunction

endpackage

// ===== design/quaternion_to_euler_angles.sv =====
// Channel  | Signals                                  | Direction
// ---------+------------------------------------------+----------
// in       | in_valid, in_ready, quat_w/x/y/z         | request in
// out      | out_valid, out_ready, pitch/roll/yaw     | request out
//
// One request enters per cycle whenever the output register is free or taken.
// The path runs through the 31-step square root pipeline and the 20-step CORDIC pipes.
// The whole pipeline advances together whenever the output register is free or taken.
// Reset clears only the valid bits; payload registers are not reset.
module quaternion_to_euler_angles (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [q2e_pkg::IN_W-1:0]       quat_w,
    input  logic signed [q2e_pkg::IN_W-1:0]       quat_x,
    input  logic signed [q2e_pkg::IN_W-1:0]       quat_y,
    input  logic signed [q2e_pkg::IN_W-1:0]       quat_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [q2e_pkg::PITCH_W-1:0]    pitch_angle,
    output logic signed [q2e_pkg::ANG_W-1:0]      roll_angle,
    output logic signed [q2e_pkg::ANG_W-1:0]      yaw_angle
);

    localparam int OPW  = q2e_pkg::OPW;
    localparam int NW   = q2e_pkg::NW;
    localparam int SQW  = q2e_pkg::SQ_W;
    localparam int SRW  = SQW + 1;
    localparam int NIT  = q2e_pkg::SQRT_ITERS;
    localparam int LAT  = q2e_pkg::TOTAL_LAT;
    localparam int CW   = q2e_pkg::Q_BITS + 1;
    localparam logic [SQW-1:0] SQ_ONE = SQW'(1) << (SQW - 1);

    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;

    q2e_pkg::prod_t wy_reg, xz_reg, yz_reg, wx_reg, xx_reg;
    q2e_pkg::prod_t yy_reg, xy_reg, wz_reg, ww_reg, zz_reg;

    q2e_pkg::opnd_t s_full, s_next, ry_next, rx_next, yy_next, yx_next;
    logic signed [NW-1:0]   s_reg;
    q2e_pkg::opnd_t ry_reg, rx_reg, qy_reg, qx_reg;

    logic signed [2*NW-1:0] sq_full;
    logic [SQW-1:0]         sq_reg;
    logic signed [NW-1:0]   s3_reg;
    q2e_pkg::opnd_t ry3_reg, rx3_reg, qy3_reg, qx3_reg;

    logic [SQW-1:0]        sv_reg [0:NIT];
    logic [SRW-1:0]        sr_reg [0:NIT];
    logic signed [NW-1:0]  ps_reg [0:NIT];
    q2e_pkg::opnd_t        pry_reg [0:NIT];
    q2e_pkg::opnd_t        prx_reg [0:NIT];
    q2e_pkg::opnd_t        pqy_reg [0:NIT];
    q2e_pkg::opnd_t        pqx_reg [0:NIT];

    q2e_pkg::opnd_t        cos_term;

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Sums of products, doubled where the formulas call for it; the pitch sine is clamped to plus or minus one.
    always_comb
    begin
        s_full  = (OPW'(wy_reg) - OPW'(xz_reg)) <<< 1;
        s_next  = s_full;
        if (s_full > OPW'(q2e_pkg::Q_ONE))
        begin
            s_next = OPW'(q2e_pkg::Q_ONE);
        end
        else if (s_full < -OPW'(q2e_pkg::Q_ONE))
        begin
            s_next = -OPW'(q2e_pkg::Q_ONE);
        end
        ry_next = (OPW'(yz_reg) + OPW'(wx_reg)) <<< 1;
        rx_next = OPW'(q2e_pkg::Q_ONE) - ((OPW'(xx_reg) + OPW'(yy_reg)) <<< 1);
        yy_next = (OPW'(xy_reg) + OPW'(wz_reg)) <<< 1;
        yx_next = OPW'(ww_reg) + OPW'(xx_reg) - OPW'(yy_reg) - OPW'(zz_reg);
    end

    assign sq_full = s_reg * s_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wy_reg     <= q2e_pkg::mulq(quat_w, quat_y);
            xz_reg     <= q2e_pkg::mulq(quat_x, quat_z);
            yz_reg     <= q2e_pkg::mulq(quat_y, quat_z);
            wx_reg     <= q2e_pkg::mulq(quat_w, quat_x);
            xx_reg     <= q2e_pkg::mulq(quat_x, quat_x);
            yy_reg     <= q2e_pkg::mulq(quat_y, quat_y);
            xy_reg     <= q2e_pkg::mulq(quat_x, quat_y);
            wz_reg     <= q2e_pkg::mulq(quat_w, quat_z);
            ww_reg     <= q2e_pkg::mulq(quat_w, quat_w);
            zz_reg     <= q2e_pkg::mulq(quat_z, quat_z);

            s_reg      <= s_next[NW-1:0];
            ry_reg     <= ry_next;
            rx_reg     <= rx_next;
            qy_reg     <= yy_next;
            qx_reg     <= yx_next;

            sq_reg     <= sq_full[SQW-1:0];
            s3_reg     <= s_reg;
            ry3_reg    <= ry_reg;
            rx3_reg    <= rx_reg;
            qy3_reg    <= qy_reg;
            qx3_reg    <= qx_reg;

            sv_reg[0]  <= SQ_ONE - sq_reg;
            sr_reg[0]  <= '0;
            ps_reg[0]  <= s3_reg;
            pry_reg[0] <= ry3_reg;
            prx_reg[0] <= rx3_reg;
            pqy_reg[0] <= qy3_reg;
            pqx_reg[0] <= qx3_reg;
        end
    end

    // Restoring square root, one result bit per stage.
    for (genvar k = 0; k < NIT; k++)
    begin : g_sqrt
        localparam logic [SRW-1:0] BIT = SRW'(1) << (SQW - 1 - 2 * k);
        logic [SRW-1:0] trial;

        assign trial = sr_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (SRW'(sv_reg[k]) >= trial)
                begin
                    sv_reg[k+1] <= sv_reg[k] - trial[SQW-1:0];
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + BIT;
                end
                else
                begin
                    sv_reg[k+1] <= sv_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
                ps_reg[k+1]  <= ps_reg[k];
                pry_reg[k+1] <= pry_reg[k];
                prx_reg[k+1] <= prx_reg[k];
                pqy_reg[k+1] <= pqy_reg[k];
                pqx_reg[k+1] <= pqx_reg[k];
            end
        end
    end

    assign cos_term = OPW'({1'b0, sr_reg[NIT][CW-1:0]});

    q2e_cordic #(
        .OUT_W   (q2e_pkg::PITCH_W),
        .OUT_LIM (q2e_pkg::PITCH_LIM)
    ) u_pitch (
        .clk   (clk),
        .en    (en),
        .num   (OPW'(ps_reg[NIT])),
        .den   (cos_term),
        .angle (pitch_angle)
    );

    q2e_cordic #(
        .OUT_W   (q2e_pkg::ANG_W),
        .OUT_LIM (q2e_pkg::ANG_LIM)
    ) u_roll (
        .clk   (clk),
        .en    (en),
        .num   (pry_reg[NIT]),
        .den   (prx_reg[NIT]),
        .angle (roll_angle)
    );

    q2e_cordic #(
        .OUT_W   (q2e_pkg::ANG_W),
        .OUT_LIM (q2e_pkg::ANG_LIM)
    ) u_yaw (
        .clk   (clk),
        .en    (en),
        .num   (pqy_reg[NIT]),
        .den   (pqx_reg[NIT]),
        .angle (yaw_angle)
    );

    assign out_valid = vld_reg[LAT-1];

endmodule

// ===== design/q2e_cordic.sv =====
module q2e_cordic #(
    parameter int OUT_W   = q2e_pkg::ANG_W,
    parameter int OUT_LIM = q2e_pkg::ANG_LIM
) (
    input  logic                          clk,
    input  logic                          en,
    input  q2e_pkg::opnd_t                num,
    input  q2e_pkg::opnd_t                den,
    output logic signed [OUT_W-1:0]       angle
);

    localparam int OPW    = q2e_pkg::OPW;
    localparam int NW     = q2e_pkg::NW;
    localparam int ZW     = q2e_pkg::ZW;
    localparam int SHW    = q2e_pkg::SHW;
    localparam int ITERS  = q2e_pkg::ITERS;
    localparam int PW     = q2e_pkg::PW;
    localparam int NQ_W   = PW - q2e_pkg::DEG_SHIFT;
    localparam int QM_W   = NQ_W + q2e_pkg::RECIP_W;
    localparam int Q0_W   = QM_W - q2e_pkg::RECIP_SHIFT;

    // Quadrant fold.
    logic signed [OPW-1:0] x0_next, y0_next;
    logic signed [ZW-1:0]  z0_next;
    logic signed [OPW-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [ZW-1:0]  z0_reg, z1_reg, z2_reg;
    logic                  zero0_reg, zero1_reg, zero2_reg;
    logic [OPW-1:0]        ay1, m1_next, m1_reg;
    logic [SHW-1:0]        pos2_next, pos2_reg, rsh, lsh;
    logic signed [OPW-1:0] xs_next, ys_next;

    logic signed [NW-1:0]  cx_reg [0:ITERS];
    logic signed [NW-1:0]  cy_reg [0:ITERS];
    logic signed [ZW-1:0]  cz_reg [0:ITERS];
    logic                  cz0_reg [0:ITERS];

    logic [ZW-1:0]         mag;
    logic [PW-1:0]         prod_next, prod_reg;
    logic                  neg4_reg, zero4_reg, neg5_reg, zero5_reg;
    logic [NQ_W-1:0]       n_next, n_reg, rem, q, q_clamp;
    logic [QM_W-1:0]       qm;
    logic [Q0_W-1:0]       q0_reg;
    logic signed [OUT_W-1:0] angle_next, angle_reg;

    always_comb
    begin
        x0_next = den;
        y0_next = num;
        z0_next = '0;
        if (den[OPW-1])
        begin
            x0_next = -den;
            y0_next = -num;
            z0_next = num[OPW-1] ? -ZW'(q2e_pkg::PI_Q24) : ZW'(q2e_pkg::PI_Q24);
        end
    end

    assign ay1     = y0_reg[OPW-1] ? OPW'(-y0_reg) : OPW'(y0_reg);
    assign m1_next = (ay1 > OPW'(x0_reg)) ? ay1 : OPW'(x0_reg);

    // Position of the leading one of the larger magnitude.
    always_comb
    begin
        pos2_next = '0;
        for (int i = 0; i < OPW; i++)
        begin
            if (m1_reg[i])
            begin
                pos2_next = SHW'(i);
            end
        end
    end

    // Scale both operands so the larger magnitude lands in [2^28, 2^29).
    assign rsh = pos2_reg - SHW'(q2e_pkg::NORM_MSB);
    assign lsh = SHW'(q2e_pkg::NORM_MSB) - pos2_reg;

    always_comb
    begin
        if (pos2_reg >= SHW'(q2e_pkg::NORM_MSB))
        begin
            xs_next = x2_reg >>> rsh;
            ys_next = y2_reg >>> rsh;
        end
        else
        begin
            xs_next = x2_reg <<< lsh;
            ys_next = y2_reg <<< lsh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg     <= x0_next;
            y0_reg     <= y0_next;
            z0_reg     <= z0_next;
            zero0_reg  <= (num == '0) && (den == '0);
            x1_reg     <= x0_reg;
            y1_reg     <= y0_reg;
            z1_reg     <= z0_reg;
            zero1_reg  <= zero0_reg;
            m1_reg     <= m1_next;
            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            z2_reg     <= z1_reg;
            zero2_reg  <= zero1_reg;
            pos2_reg   <= pos2_next;
            cx_reg[0]  <= xs_next[NW-1:0];
            cy_reg[0]  <= ys_next[NW-1:0];
            cz_reg[0]  <= z2_reg;
            cz0_reg[0] <= zero2_reg;
        end
    end

    for (genvar i = 0; i < ITERS; i++)
    begin : g_iter
        logic signed [NW-1:0] dx, dy;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cz0_reg[i+1] <= cz0_reg[i];
                if (!cy_reg[i][NW-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + q2e_pkg::atan_q24(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - q2e_pkg::atan_q24(i);
                end
            end
        end
    end

    // Degree scaling; the divide by five is a reciprocal multiply plus one correction.
    assign mag       = cz_reg[ITERS][ZW-1] ? ZW'(-cz_reg[ITERS]) : ZW'(cz_reg[ITERS]);
    assign prod_next = PW'(mag) * PW'(q2e_pkg::DEG_MUL) + PW'(q2e_pkg::DEG_RND);
    assign n_next    = prod_reg[PW-1:q2e_pkg::DEG_SHIFT];
    assign qm        = QM_W'(n_next) * QM_W'(q2e_pkg::RECIP);
    assign rem       = n_reg - NQ_W'(q0_reg) * NQ_W'(q2e_pkg::DEG_DIV);
    assign q         = NQ_W'(q0_reg) + NQ_W'(rem >= NQ_W'(q2e_pkg::DEG_DIV));
    assign q_clamp   = (q > NQ_W'(OUT_LIM)) ? NQ_W'(OUT_LIM) : q;

    always_comb
    begin
        if (zero5_reg)
        begin
            angle_next = '0;
        end
        else if (neg5_reg)
        begin
            angle_next = -OUT_W'(q_clamp);
        end
        else
        begin
            angle_next = OUT_W'(q_clamp);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            neg4_reg  <= cz_reg[ITERS][ZW-1];
            zero4_reg <= cz0_reg[ITERS];
            n_reg     <= n_next;
            q0_reg    <= qm[QM_W-1:q2e_pkg::RECIP_SHIFT];
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// ===== design/q2e_checker.sv =====
module q2e_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [q2e_pkg::PITCH_W-1:0]  pitch_angle,
    input logic signed [q2e_pkg::ANG_W-1:0]    roll_angle,
    input logic signed [q2e_pkg::ANG_W-1:0]    yaw_angle
);

`include "quaternion_to_euler_angles_macros.svh"

    // A stalled result stays put.
    `Q2E_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pitch_angle) && $stable(roll_angle) && $stable(yaw_angle), "result changed while stalled")

    // The block takes a request whenever its output is not stalled.
    `Q2E_ASSERT_SAME(a_in_ready, !out_valid || out_ready, in_ready, "request refused with free output")

    `Q2E_ASSERT_SAME(a_pitch_rng, out_valid, (pitch_angle <= q2e_pkg::PITCH_W'(q2e_pkg::PITCH_LIM)) && (pitch_angle >= -q2e_pkg::PITCH_W'(q2e_pkg::PITCH_LIM)), "pitch out of range")

    `Q2E_ASSERT_SAME(a_ang_rng, out_valid, (roll_angle <= q2e_pkg::ANG_W'(q2e_pkg::ANG_LIM)) && (roll_angle >= -q2e_pkg::ANG_W'(q2e_pkg::ANG_LIM)) && (yaw_angle <= q2e_pkg::ANG_W'(q2e_pkg::ANG_LIM)) && (yaw_angle >= -q2e_pkg::ANG_W'(q2e_pkg::ANG_LIM)), "roll or yaw out of range")

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle),
    .yaw_angle   (yaw_angle)
);
